/* rtl/cevs_pkg.sv */
// ----------------------------------------------------------------------------
// cevs_pkg
// Types and constants shared by the eviction victim select blocks.
// ----------------------------------------------------------------------------
package cevs_pkg;

    localparam int TIME_W = 32;
    localparam int SLOT_W = 8;

    typedef enum logic [1:0] {
        REASON_STALE    = 2'd0,
        REASON_LRU      = 2'd1,
        REASON_FALLBACK = 2'd2
    } reason_t;

    // One slot record as carried by an input transaction
    typedef struct packed {
        logic              occupied;
        logic [TIME_W-1:0] inserted_at;
        logic [TIME_W-1:0] max_age;
        logic [TIME_W-1:0] accessed_at;
        logic [TIME_W-1:0] now;
        logic              last_slot;
    } slot_rec_t;

    // Outcome of one scan
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] victim_slot;
        reason_t           reason;
    } victim_t;

endpackage

/* rtl/cevs_in_stage.sv */
// ----------------------------------------------------------------------------
// cevs_in_stage
// Input register for slot records; holds a record until the scan takes it.
// ----------------------------------------------------------------------------
module cevs_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cevs_pkg::slot_rec_t in_rec,
    input  logic                advance,
    output logic                rec_valid,
    output cevs_pkg::slot_rec_t rec
);
    import cevs_pkg::*;

    logic      valid_reg;
    slot_rec_t rec_reg;

    assign in_stall  = valid_reg && !advance;
    assign rec_valid = valid_reg;
    assign rec       = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            rec_reg <= in_rec;
        end
    end

endmodule

/* rtl/cevs_scan.sv */
// ----------------------------------------------------------------------------
// cevs_scan
// Running scan state: stale search, least recent access, last occupied slot.
// ----------------------------------------------------------------------------
module cevs_scan #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  cevs_pkg::slot_rec_t rec,
    output cevs_pkg::victim_t   result
);
    import cevs_pkg::*;

    localparam int CNT_MIN = $clog2(TABLE_SLOTS + 1);
    localparam int CNT_W   = (CNT_MIN > SLOT_W) ? CNT_MIN : SLOT_W;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              stale_seen_reg, stale_seen_next;
    logic [SLOT_W-1:0] stale_index_reg, stale_index_next;
    logic              oldest_seen_reg, oldest_seen_next;
    logic [TIME_W-1:0] oldest_access_reg, oldest_access_next;
    logic [SLOT_W-1:0] oldest_index_reg, oldest_index_next;
    logic              any_seen_reg, any_seen_next;
    logic [SLOT_W-1:0] latest_index_reg, latest_index_next;

    logic              in_range;
    logic              take;
    logic [SLOT_W-1:0] idx;
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] bound;
    logic              stale_hit;
    logic              lru_hit;

    assign in_range  = count_reg < CNT_W'(TABLE_SLOTS);
    assign idx       = count_reg[SLOT_W-1:0];
    assign take      = in_range && rec.occupied && !stale_seen_reg;
    assign age       = rec.now - rec.inserted_at;
    assign bound     = oldest_seen_reg ? oldest_access_reg : rec.now;
    assign stale_hit = take && (age >= rec.max_age);
    assign lru_hit   = take && !stale_hit && (rec.accessed_at < bound);

    always_comb
    begin
        count_next         = in_range ? count_reg + CNT_W'(1) : count_reg;
        stale_seen_next    = stale_seen_reg | stale_hit;
        stale_index_next   = stale_hit ? idx : stale_index_reg;
        oldest_seen_next   = oldest_seen_reg | lru_hit;
        oldest_access_next = lru_hit ? rec.accessed_at : oldest_access_reg;
        oldest_index_next  = lru_hit ? idx : oldest_index_reg;
        any_seen_next      = any_seen_reg | take;
        latest_index_next  = take ? idx : latest_index_reg;
    end

    // Verdict including the current slot
    always_comb
    begin
        result.found       = 1'b0;
        result.victim_slot = '0;
        result.reason      = REASON_STALE;
        if (stale_seen_next)
        begin
            result.found       = 1'b1;
            result.victim_slot = stale_index_next;
        end
        else if (oldest_seen_next)
        begin
            result.found       = 1'b1;
            result.victim_slot = oldest_index_next;
            result.reason      = REASON_LRU;
        end
        else if (any_seen_next)
        begin
            result.found       = 1'b1;
            result.victim_slot = latest_index_next;
            result.reason      = REASON_FALLBACK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            stale_seen_reg    <= 1'b0;
            stale_index_reg   <= '0;
            oldest_seen_reg   <= 1'b0;
            oldest_access_reg <= '0;
            oldest_index_reg  <= '0;
            any_seen_reg      <= 1'b0;
            latest_index_reg  <= '0;
        end
        else if (fire)
        begin
            if (rec.last_slot)
            begin
                count_reg         <= '0;
                stale_seen_reg    <= 1'b0;
                stale_index_reg   <= '0;
                oldest_seen_reg   <= 1'b0;
                oldest_access_reg <= '0;
                oldest_index_reg  <= '0;
                any_seen_reg      <= 1'b0;
                latest_index_reg  <= '0;
            end
            else
            begin
                count_reg         <= count_next;
                stale_seen_reg    <= stale_seen_next;
                stale_index_reg   <= stale_index_next;
                oldest_seen_reg   <= oldest_seen_next;
                oldest_access_reg <= oldest_access_next;
                oldest_index_reg  <= oldest_index_next;
                any_seen_reg      <= any_seen_next;
                latest_index_reg  <= latest_index_next;
            end
        end
    end

endmodule

/* rtl/cevs_out_stage.sv */
// ----------------------------------------------------------------------------
// cevs_out_stage
// Result register; holds a verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module cevs_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cevs_pkg::victim_t result,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_stall,
    output cevs_pkg::victim_t out_result
);
    import cevs_pkg::*;

    logic    valid_reg;
    victim_t result_reg;

    assign busy       = valid_reg && out_stall;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

/* rtl/cache_eviction_victim_select.sv */
// Path: input register, then scan logic; a record that carries last_slot
//   loads its verdict into the result register; other records emit none.
// Throughput: one slot record per cycle; each takes one subtract and two
//   compares. A closing record waits only while a held verdict is stalled.
// Reset: asynchronous, active low; clears scan state and both valid flags.
// ----------------------------------------------------------------------------
// cache_eviction_victim_select
// Scans a cache table one slot per transaction and picks an eviction victim:
// first stale slot, else least recently accessed, else last occupied slot.
// ----------------------------------------------------------------------------
module cache_eviction_victim_select #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // slot record channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          occupied,
    input  logic [cevs_pkg::TIME_W-1:0]   inserted_at,
    input  logic [cevs_pkg::TIME_W-1:0]   max_age,
    input  logic [cevs_pkg::TIME_W-1:0]   accessed_at,
    input  logic [cevs_pkg::TIME_W-1:0]   now,
    input  logic                          last_slot,
    // verdict channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [cevs_pkg::SLOT_W-1:0]   victim_slot,
    output logic [1:0]                    reason
);
    import cevs_pkg::*;

    slot_rec_t in_rec;
    slot_rec_t rec;
    logic      rec_valid;
    logic      advance;
    logic      fire;
    logic      out_busy;
    victim_t   result;
    victim_t   out_result;

    assign in_rec.occupied    = occupied;
    assign in_rec.inserted_at = inserted_at;
    assign in_rec.max_age     = max_age;
    assign in_rec.accessed_at = accessed_at;
    assign in_rec.now         = now;
    assign in_rec.last_slot   = last_slot;

    // A record that closes the scan needs the result register free (or being
    // emptied this cycle); every other record moves on unconditionally.
    assign advance = !rec.last_slot || !out_busy;
    assign fire    = rec_valid && advance;

    cevs_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_rec    (in_rec),
        .advance   (advance),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // Running scan state and the verdict logic
    cevs_scan #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .rec    (rec),
        .result (result)
    );

    cevs_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire && rec.last_slot),
        .result     (result),
        .busy       (out_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign found       = out_result.found;
    assign victim_slot = out_result.victim_slot;
    assign reason      = out_result.reason;

endmodule
